// ===== design/b2da_pkg.sv =====
package b2da_pkg;

  // ASCII codes used for the text.
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // take a new value and clear the digit register
    logic conv_step;   // one shift-and-add-3 step
    logic trim_step;   // drop one leading zero digit
    logic emit_sign;   // load '-' into the output register
    logic emit_digit;  // load the leading digit into the output register
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic conv_done;   // the current step is the last conversion step
    logic top_zero;    // the leading digit is zero
    logic dig_one;     // one digit remains
    logic neg;         // the value is negative
  } dp_stat_t;

endpackage

// ===== design/binary_to_decimal_ascii.sv =====
// A request is loaded, converted bit by bit, trimmed of k leading zero digits
// (k from 0 to NDIG-1), then sent as a '-' sign when negative and the remaining digits.
// A new value is taken once the last character is in the output register; output stalls
// hold the sign and digit output. Trimming and digit output together always handle NDIG digits.
// Reset: rst_ni is asynchronous and active low; it returns the controller to idle
// and drops the output valid. Payload registers are not reset.
module binary_to_decimal_ascii #(
  parameter int VALUE_WIDTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] value_bits_i,
  input  logic        is_signed_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  text_char_o,
  output logic        last_char_o
);
  import b2da_pkg::*;

  // The controller sequences one request at a time: load, convert, trim the
  // leading zeros, then hand out the sign and the digits one per handshake.
  // A new request is taken as soon as the last character sits in the output
  // register, even if the consumer has not taken it yet.
  dp_cmd_t  cmd;
  dp_stat_t stat;

  b2da_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // The datapath holds the magnitude, the packed BCD digits, the counters and
  // the output character register.
  b2da_datapath #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .value_bits_i (value_bits_i),
    .is_signed_i  (is_signed_i),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .text_char_o  (text_char_o),
    .last_char_o  (last_char_o)
  );

endmodule

// ===== design/b2da_datapath.sv =====
module b2da_datapath #(
  parameter int VALUE_WIDTH = 64
) (
  input  logic               clk_i,
  input  logic [63:0]        value_bits_i,
  input  logic               is_signed_i,
  input  b2da_pkg::dp_cmd_t  cmd_i,
  output b2da_pkg::dp_stat_t stat_o,
  output logic [7:0]         text_char_o,
  output logic               last_char_o
);
  import b2da_pkg::*;

  // Decimal digits needed for 2^VALUE_WIDTH - 1 (log10(2) ~ 0.30103).
  localparam int NDIG = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int BCDW = 4 * NDIG;
  localparam int BCW  = $clog2(VALUE_WIDTH);
  localparam int DCW  = $clog2(NDIG + 1);

  logic [VALUE_WIDTH-1:0] raw;
  logic                   neg_in;
  logic [VALUE_WIDTH-1:0] mag;
  logic [BCDW-1:0]        adj;

  logic [VALUE_WIDTH-1:0] bin_q;
  logic [BCDW-1:0]        bcd_q;
  logic [BCW-1:0]         bit_cnt_q;
  logic [DCW-1:0]         dig_cnt_q;
  logic                   neg_q;
  logic [7:0]             char_q;
  logic                   last_q;

  assign raw    = value_bits_i[VALUE_WIDTH-1:0];
  assign neg_in = is_signed_i & raw[VALUE_WIDTH-1];
  // Two's complement negation wraps, so the most negative value is exact.
  assign mag    = neg_in ? (~raw + 1'b1) : raw;

  // Digits of five or more get 3 added before the shift.
  always_comb begin
    adj = bcd_q;
    for (int i = 0; i < NDIG; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      bin_q     <= mag;
      bcd_q     <= '0;
      bit_cnt_q <= '0;
      dig_cnt_q <= DCW'(NDIG);
      neg_q     <= neg_in;
    end else if (cmd_i.conv_step) begin
      bcd_q     <= {adj[BCDW-2:0], bin_q[VALUE_WIDTH-1]};
      bin_q     <= {bin_q[VALUE_WIDTH-2:0], 1'b0};
      bit_cnt_q <= bit_cnt_q + 1'b1;
    end else if (cmd_i.trim_step || cmd_i.emit_digit) begin
      bcd_q     <= {bcd_q[BCDW-5:0], 4'h0};
      dig_cnt_q <= dig_cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_sign) begin
      char_q <= CHAR_MINUS;
      last_q <= 1'b0;
    end else if (cmd_i.emit_digit) begin
      char_q <= CHAR_ZERO + {4'h0, bcd_q[BCDW-1 -: 4]};
      last_q <= (dig_cnt_q == DCW'(1));
    end
  end

  assign stat_o.conv_done = (bit_cnt_q == BCW'(VALUE_WIDTH - 1));
  assign stat_o.top_zero  = (bcd_q[BCDW-1 -: 4] == 4'h0);
  assign stat_o.dig_one   = (dig_cnt_q == DCW'(1));
  assign stat_o.neg       = neg_q;

  assign text_char_o = char_q;
  assign last_char_o = last_q;

endmodule

// ===== design/b2da_ctrl.sv =====
module b2da_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  b2da_pkg::dp_stat_t stat_i,
  output b2da_pkg::dp_cmd_t  cmd_o
);
  import b2da_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CONV  = 3'd1;
  localparam logic [2:0] ST_TRIM  = 3'd2;
  localparam logic [2:0] ST_SIGN  = 3'd3;
  localparam logic [2:0] ST_DIGIT = 3'd4;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd_o.conv_step = 1'b1;
        if (stat_i.conv_done) begin
          state_d = ST_TRIM;
        end
      end
      ST_TRIM: begin
        if (!stat_i.top_zero || stat_i.dig_one) begin
          state_d = stat_i.neg ? ST_SIGN : ST_DIGIT;
        end else begin
          cmd_o.trim_step = 1'b1;
        end
      end
      ST_SIGN: begin
        if (slot_free) begin
          cmd_o.emit_sign = 1'b1;
          state_d         = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        if (slot_free) begin
          cmd_o.emit_digit = 1'b1;
          if (stat_i.dig_one) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.emit_sign || cmd_o.emit_digit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule
